### rtl/core/gsr_pkg.sv
// Package for the gate step recorder core.
// Holds the sizes, register indexes and shared types that the other files use.
// No dependencies.

package gsr_pkg;

    // Length of the gate memory; step positions run from 1 to MAX_STEPS - 1.
    localparam int MAX_STEPS = 32;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int LEN_W     = STEP_W + 1;

    // Field widths.
    localparam int MV_W    = 15;
    localparam int THR_W   = 14;
    localparam int PULSE_W = 16;
    localparam int REQ_W   = 8;

    // Stream widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    // Configuration port widths.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLOCK_LOW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REC_THR    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAIN_PULSE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LED_PULSE  = 3'd4;

    // Reset values of the registers.
    localparam logic [THR_W-1:0]   CLOCK_HIGH_RST = 14'd1700;
    localparam logic [THR_W-1:0]   CLOCK_LOW_RST  = 14'd200;
    localparam logic [THR_W-1:0]   REC_THR_RST    = 14'd200;
    localparam logic [PULSE_W-1:0] MAIN_PULSE_RST = 16'd5;
    localparam logic [PULSE_W-1:0] LED_PULSE_RST  = 16'd2400;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [THR_W-1:0]   clock_high_mv;
        logic [THR_W-1:0]   clock_low_mv;
        logic [THR_W-1:0]   rec_cv_threshold_mv;
        logic [PULSE_W-1:0] main_pulse_samples;
        logic [PULSE_W-1:0] led_pulse_samples;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [REQ_W-1:0] steps_request;
        logic             manual_press;
        logic             rec_cv_connected;
        logic [MV_W-1:0]  rec_cv_mv;
        logic             rec_press;
        logic             gate_connected;
        logic [MV_W-1:0]  gate_mv;
        logic             clock_connected;
        logic [MV_W-1:0]  clock_mv;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // Sequencer status handed to the pulse generators and the output stage.
    typedef struct packed {
        logic              fire;
        logic              recording;
        logic [STEP_W-1:0] step;
    } seq_stat_t;

endpackage

### rtl/core/gate_step_recorder_core.sv
// Top level of the gate step recorder core: stream ports, input and result
// registers, and the sequencer, pulse and configuration blocks.
// Depends on gsr_pkg, gsr_cfg_regs, gsr_seq and gsr_pulse.

// The core accepts one sample item per clock cycle and returns one result
// item for each, in order; that rate is set by the single-pass update and
// drops only while the receiver holds off. An item waits in the input
// register, where the sequencer and both pulse counters update in a
// single pass, and its result is then registered in the output register,
// which drives tvalid. The output register holds a stalled result while
// the input register can still take one more item. Registers are written
// over APB at byte addresses 0x00 clock high, 0x04 clock low, 0x08 record
// CV threshold, 0x0C trigger length, 0x10 LED length; write them only
// while idle.

module gate_step_recorder_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items: clock_mv[14:0], clock_connected[15], gate_mv[30:16],
    // gate_connected[31], rec_press[32], rec_cv_mv[47:33],
    // rec_cv_connected[48], manual_press[49], steps_request[57:50], zero above.
    input  logic [gsr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Result items: trigger_out[0], step_led[1], recording_on[2],
    // step_index[7:3].
    output logic [gsr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gsr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gsr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    gsr_pkg::cfg_t      cfg;
    gsr_pkg::item_t     item_reg;
    gsr_pkg::seq_stat_t stat;
    logic               in_vld_reg;
    logic               out_vld_reg;
    logic [gsr_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic               out_free;
    logic               advance;
    logic               trig_active;
    logic               led_active;
    logic [gsr_pkg::STEP_W-1:0] pos_now;

    // Handshake: the input register moves on whenever the result register
    // is empty or being emptied.
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    gsr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gsr_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .stat    (stat),
        .pos_now (pos_now)
    );

    gsr_pulse u_trig
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .fire      (stat.fire),
        .pulse_len (cfg.main_pulse_samples),
        .active    (trig_active)
    );

    gsr_pulse u_led
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .fire      (stat.fire),
        .pulse_len (cfg.led_pulse_samples),
        .active    (led_active)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_tdata[gsr_pkg::ITEM_W-1:0];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {stat.step, stat.recording, led_active, trig_active};
    end

    // A waiting item with room downstream yields a result on the next edge.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result missing after item advanced");

    // The step position never leaves 1..MAX_STEPS-1.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_now != '0)
        else $error("step position reached zero");

    // Reported step index is never zero.
    a_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] != '0)
        else $error("result carries step index zero");

    // A stalled result is not overwritten by a new item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !advance)
        else $error("stalled result overwritten");

endmodule

### rtl/core/gsr_cfg_regs.sv
// Configuration register file of the gate step recorder, on an APB-style port.
// Depends on gsr_pkg.

module gsr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gsr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output gsr_pkg::cfg_t                  cfg
);

    gsr_pkg::cfg_t cfg_reg;
    logic [gsr_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gsr_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_high_mv       <= gsr_pkg::CLOCK_HIGH_RST;
            cfg_reg.clock_low_mv        <= gsr_pkg::CLOCK_LOW_RST;
            cfg_reg.rec_cv_threshold_mv <= gsr_pkg::REC_THR_RST;
            cfg_reg.main_pulse_samples  <= gsr_pkg::MAIN_PULSE_RST;
            cfg_reg.led_pulse_samples   <= gsr_pkg::LED_PULSE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gsr_pkg::REG_CLOCK_HIGH:
                    cfg_reg.clock_high_mv <= pwdata[gsr_pkg::THR_W-1:0];
                gsr_pkg::REG_CLOCK_LOW:
                    cfg_reg.clock_low_mv <= pwdata[gsr_pkg::THR_W-1:0];
                gsr_pkg::REG_REC_THR:
                    cfg_reg.rec_cv_threshold_mv <= pwdata[gsr_pkg::THR_W-1:0];
                gsr_pkg::REG_MAIN_PULSE:
                    cfg_reg.main_pulse_samples <= pwdata[gsr_pkg::PULSE_W-1:0];
                gsr_pkg::REG_LED_PULSE:
                    cfg_reg.led_pulse_samples <= pwdata[gsr_pkg::PULSE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            gsr_pkg::REG_CLOCK_HIGH:
                prdata = {{(gsr_pkg::APB_DATA_W-gsr_pkg::THR_W){1'b0}},
                          cfg_reg.clock_high_mv};
            gsr_pkg::REG_CLOCK_LOW:
                prdata = {{(gsr_pkg::APB_DATA_W-gsr_pkg::THR_W){1'b0}},
                          cfg_reg.clock_low_mv};
            gsr_pkg::REG_REC_THR:
                prdata = {{(gsr_pkg::APB_DATA_W-gsr_pkg::THR_W){1'b0}},
                          cfg_reg.rec_cv_threshold_mv};
            gsr_pkg::REG_MAIN_PULSE:
                prdata = {{(gsr_pkg::APB_DATA_W-gsr_pkg::PULSE_W){1'b0}},
                          cfg_reg.main_pulse_samples};
            gsr_pkg::REG_LED_PULSE:
                prdata = {{(gsr_pkg::APB_DATA_W-gsr_pkg::PULSE_W){1'b0}},
                          cfg_reg.led_pulse_samples};
            default:
                prdata = '0;
        endcase
    end

endmodule

### rtl/core/gsr_seq.sv
// Step sequencer of the gate step recorder: record flag, clock hysteresis,
// step position and the gate memory of one bit per step. Depends on gsr_pkg.

module gsr_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  gsr_pkg::item_t     item,
    input  gsr_pkg::cfg_t      cfg,
    output gsr_pkg::seq_stat_t stat,
    output logic [gsr_pkg::STEP_W-1:0] pos_now
);

    localparam int MAX_STEPS = gsr_pkg::MAX_STEPS;
    localparam int STEP_W    = gsr_pkg::STEP_W;
    localparam int LEN_W     = gsr_pkg::LEN_W;
    localparam int CMP_W     = gsr_pkg::MV_W + 1;

    logic [MAX_STEPS-1:0] gate_mem_reg;
    logic [MAX_STEPS-1:0] gate_mem_next;
    logic [STEP_W-1:0]    pos_reg;
    logic [STEP_W-1:0]    pos_next;
    logic                 rec_reg;
    logic                 rec_next;
    logic                 armed_reg;
    logic                 armed_next;
    logic                 btn_last_reg;
    logic                 btn_last_next;

    logic signed [CMP_W-1:0] clock_s;
    logic signed [CMP_W-1:0] rec_cv_s;
    logic signed [CMP_W-1:0] high_s;
    logic signed [CMP_W-1:0] low_s;
    logic signed [CMP_W-1:0] rthr_s;
    logic                    gate_pos;
    logic [LEN_W-1:0]        len;
    logic [STEP_W-1:0]       pos_base;
    logic [LEN_W-1:0]        pos_inc;
    logic                    edge_det;
    logic                    cur_bit;
    logic                    set_bit;

    // Sign-extended samples against zero-extended thresholds.
    assign clock_s  = {item.clock_mv[gsr_pkg::MV_W-1], item.clock_mv};
    assign rec_cv_s = {item.rec_cv_mv[gsr_pkg::MV_W-1], item.rec_cv_mv};
    assign high_s   = {{(CMP_W-gsr_pkg::THR_W){1'b0}}, cfg.clock_high_mv};
    assign low_s    = {{(CMP_W-gsr_pkg::THR_W){1'b0}}, cfg.clock_low_mv};
    assign rthr_s   = {{(CMP_W-gsr_pkg::THR_W){1'b0}}, cfg.rec_cv_threshold_mv};
    assign gate_pos = !item.gate_mv[gsr_pkg::MV_W-1] && (item.gate_mv != '0);

    // Step length saturated to 1..MAX_STEPS.
    always_comb
    begin
        priority if (item.steps_request[gsr_pkg::REQ_W-1] || item.steps_request == '0)
            len = LEN_W'(1);
        else if (item.steps_request > gsr_pkg::REQ_W'(MAX_STEPS))
            len = LEN_W'(MAX_STEPS);
        else
            len = item.steps_request[LEN_W-1:0];
    end

    // Record flag from button edge or CV level; button start resets step.
    always_comb
    begin
        rec_next      = rec_reg;
        btn_last_next = btn_last_reg;
        pos_base      = pos_reg;
        if (item.rec_cv_connected)
        begin
            rec_next = rec_cv_s > rthr_s;
        end
        else if (btn_last_reg)
        begin
            if (!item.rec_press)
                btn_last_next = 1'b0;
        end
        else if (item.rec_press)
        begin
            btn_last_next = 1'b1;
            rec_next      = !rec_reg;
            if (!rec_reg)
                pos_base = STEP_W'(1);
        end
    end

    // Clock edge with hysteresis, step advance and gate memory update.
    always_comb
    begin
        armed_next    = armed_reg;
        edge_det      = 1'b0;
        pos_next      = pos_base;
        gate_mem_next = gate_mem_reg;
        pos_inc       = {1'b0, pos_base} + LEN_W'(1);
        if (item.clock_connected)
        begin
            if (armed_reg)
            begin
                if (clock_s <= low_s)
                    armed_next = 1'b0;
            end
            else if (clock_s >= high_s)
            begin
                armed_next = 1'b1;
                edge_det   = 1'b1;
            end
        end
        if (edge_det)
        begin
            if (pos_inc >= len || pos_inc >= LEN_W'(MAX_STEPS))
                pos_next = STEP_W'(1);
            else
                pos_next = pos_inc[STEP_W-1:0];
        end
        cur_bit = gate_mem_reg[pos_next];
        set_bit = cur_bit;
        if (rec_next)
        begin
            if (item.gate_connected)
                set_bit = gate_pos;
            if (item.manual_press)
                set_bit = 1'b1;
        end
        if (edge_det)
            gate_mem_next[pos_next] = set_bit;
    end

    assign stat.fire      = edge_det && set_bit;
    assign stat.recording = rec_next;
    assign stat.step      = pos_next;
    assign pos_now        = pos_reg;

    // State update once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mem_reg <= '0;
            pos_reg      <= STEP_W'(1);
            rec_reg      <= 1'b0;
            armed_reg    <= 1'b1;
            btn_last_reg <= 1'b1;
        end
        else if (advance)
        begin
            gate_mem_reg <= gate_mem_next;
            pos_reg      <= pos_next;
            rec_reg      <= rec_next;
            armed_reg    <= armed_next;
            btn_last_reg <= btn_last_next;
        end
    end

endmodule

### rtl/core/gsr_pulse.sv
// Retriggerable pulse counter of the gate step recorder.
// Depends on gsr_pkg.

module gsr_pulse
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        fire,
    input  logic [gsr_pkg::PULSE_W-1:0] pulse_len,
    output logic                        active
);

    logic [gsr_pkg::PULSE_W-1:0] remain_reg;
    logic [gsr_pkg::PULSE_W-1:0] remain_next;
    logic [gsr_pkg::PULSE_W-1:0] loaded;

    // A retrigger takes the longer of what remains and the full length.
    always_comb
    begin
        loaded = remain_reg;
        if (fire && pulse_len > remain_reg)
            loaded = pulse_len;
        active      = loaded != '0;
        remain_next = active ? loaded - gsr_pkg::PULSE_W'(1) : loaded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remain_reg <= '0;
        else if (advance)
            remain_reg <= remain_next;
    end

endmodule
